FILE: hw/rtl/pidc_pkg.sv
// Shared types and constants for the clamped PID controller.
// No dependencies; every other file of the block refers to this package.
package pidc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ERR_W       = SAMPLE_W + 1;
    localparam int DIFF_W      = SAMPLE_W + 2;
    localparam int GAIN_W      = 16;
    localparam int ILIM_W      = 23;
    localparam int OLIM_W      = 15;
    localparam int INTEG_W     = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

    localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic                     diff_valid;
    } entry_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0]        integral_limit;
        logic [OLIM_W-1:0]        output_limit;
    } cfg_t;

endpackage

FILE: hw/rtl/pidc_if.sv
// Valid/ready channel interfaces for sample words and drive words.
// Depends on pidc_pkg for field widths.
interface pidc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidc_pkg::SAMPLE_W-1:0]  target;
    logic signed [pidc_pkg::SAMPLE_W-1:0]  measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pidc_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidc_pkg::SAMPLE_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

FILE: hw/rtl/pidc_front.sv
// Front end: accepts sample words, forms the error and its difference.
// Depends on pidc_pkg and pidc_req_if.
module pidc_front
(
    input  logic                clk,
    input  logic                rst_n,
    pidc_req_if.sink            req,
    input  logic                queue_ready,
    output logic                push,
    output pidc_pkg::entry_t    entry
);

    logic signed [pidc_pkg::ERR_W-1:0] prev_err_reg;
    logic signed [pidc_pkg::ERR_W-1:0] prev_err_next;
    logic                              seen_reg;
    logic                              seen_next;
    logic signed [pidc_pkg::ERR_W-1:0] err;

    assign req.ready = queue_ready;
    assign push      = req.valid && queue_ready;

    assign err = $signed({req.target[pidc_pkg::SAMPLE_W-1], req.target})
               - $signed({req.measured[pidc_pkg::SAMPLE_W-1], req.measured});

    always_comb
    begin
        entry.err        = err;
        entry.diff       = $signed({err[pidc_pkg::ERR_W-1], err})
                         - $signed({prev_err_reg[pidc_pkg::ERR_W-1], prev_err_reg});
        entry.diff_valid = seen_reg;
        prev_err_next    = prev_err_reg;
        seen_next        = seen_reg;
        if (push)
        begin
            prev_err_next = err;
            seen_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/pidc_fifo.sv
// Short queue of error words between front end and back end.
// Depends on pidc_pkg for the entry type.
module pidc_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pidc_pkg::entry_t    push_entry,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output pidc_pkg::entry_t    head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    pidc_pkg::entry_t  store_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_push;
    logic              do_pop;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/pidc_back.sv
// Back end: gain products, clamped integral, drive sum and clamp, output word.
// Depends on pidc_pkg and pidc_rsp_if.
module pidc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  pidc_pkg::cfg_t      cfg,
    input  logic                queue_not_empty,
    input  pidc_pkg::entry_t    head,
    output logic                pop,
    pidc_rsp_if.source          rsp
);

    localparam int PT_W  = pidc_pkg::GAIN_W + pidc_pkg::ERR_W - 8;
    localparam int DT_W  = pidc_pkg::GAIN_W + pidc_pkg::DIFF_W - 8;
    localparam int IS_W  = PT_W + 1;
    localparam int PD_W  = DT_W + 1;
    localparam int TOT_W = PD_W + 1;

    logic                                      advance;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::ERR_W-1:0]  p_prod;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::ERR_W-1:0]  i_prod;
    logic signed [pidc_pkg::GAIN_W+pidc_pkg::DIFF_W-1:0] d_prod;

    logic                                      s1_valid_reg;
    logic signed [PT_W-1:0]                    s1_p_reg;
    logic signed [PT_W-1:0]                    s1_i_reg;
    logic signed [DT_W-1:0]                    s1_d_reg;

    logic                                      s2_valid_reg;
    logic signed [PD_W-1:0]                    s2_pd_reg;
    logic signed [pidc_pkg::INTEG_W-1:0]       integral_reg;
    logic signed [pidc_pkg::INTEG_W-1:0]       integral_next;
    logic signed [IS_W-1:0]                    isum;
    logic signed [IS_W-1:0]                    ilim;

    logic                                      out_valid_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]      drive_reg;
    logic signed [pidc_pkg::SAMPLE_W-1:0]      drive_next;
    logic signed [TOT_W-1:0]                   total;
    logic signed [TOT_W-1:0]                   olim;

    assign advance   = !out_valid_reg || rsp.ready;
    assign pop       = advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.drive = drive_reg;

    assign p_prod = cfg.gain_p * head.err;
    assign i_prod = cfg.gain_i * head.err;
    assign d_prod = cfg.gain_d * head.diff;

    always_comb
    begin
        isum = $signed({{(IS_W-pidc_pkg::INTEG_W){integral_reg[pidc_pkg::INTEG_W-1]}},
                        integral_reg})
             + $signed({s1_i_reg[PT_W-1], s1_i_reg});
        ilim = $signed({{(IS_W-pidc_pkg::ILIM_W){1'b0}}, cfg.integral_limit});
        if (isum > ilim)
        begin
            integral_next = pidc_pkg::INTEG_W'(ilim);
        end
        else if (isum < -ilim)
        begin
            integral_next = pidc_pkg::INTEG_W'(-ilim);
        end
        else
        begin
            integral_next = pidc_pkg::INTEG_W'(isum);
        end
    end

    always_comb
    begin
        total = $signed({s2_pd_reg[PD_W-1], s2_pd_reg})
              + $signed({{(TOT_W-pidc_pkg::INTEG_W){integral_reg[pidc_pkg::INTEG_W-1]}},
                         integral_reg});
        olim  = $signed({{(TOT_W-pidc_pkg::OLIM_W){1'b0}}, cfg.output_limit});
        if (total > olim)
        begin
            drive_next = pidc_pkg::SAMPLE_W'(olim);
        end
        else if (total < -olim)
        begin
            drive_next = pidc_pkg::SAMPLE_W'(-olim);
        end
        else
        begin
            drive_next = pidc_pkg::SAMPLE_W'(total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_p_reg  <= p_prod[pidc_pkg::GAIN_W+pidc_pkg::ERR_W-1:8];
            s1_i_reg  <= i_prod[pidc_pkg::GAIN_W+pidc_pkg::ERR_W-1:8];
            s1_d_reg  <= head.diff_valid ? d_prod[pidc_pkg::GAIN_W+pidc_pkg::DIFF_W-1:8]
                                         : '0;
            s2_pd_reg <= $signed({{(PD_W-PT_W){s1_p_reg[PT_W-1]}}, s1_p_reg})
                       + $signed({s1_d_reg[DT_W-1], s1_d_reg});
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= queue_not_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                integral_reg <= integral_next;
            end
        end
    end

endmodule

FILE: hw/rtl/pid_controller_clamped.sv
// Top level of the clamped PID controller: configuration registers and wiring.
// Depends on pidc_pkg, pidc_if, pidc_front, pidc_fifo and pidc_back.
//
//   channel   | role   | word                     | transfer
//   req       | sink   | target, measured (s16)   | valid && ready
//   rsp       | source | drive (s16)              | valid && ready
//   cfg       | write  | cfg_index, cfg_data      | cfg_we
//
// One word per cycle sustained while rsp is ready; each taken sample word passes
// through the queue, product stage, integral stage and output register. Reset
// clears the integral, the previous error, all gains and the integral limit;
// the output limit comes up at its maximum. A stalled rsp freezes the back end; the
// queue keeps taking req words until it holds QUEUE_DEPTH, then req.ready drops.
module pid_controller_clamped
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    pidc_req_if.sink                            req,
    pidc_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pidc_pkg::cfg_t   cfg_reg;
    pidc_pkg::cfg_t   cfg_next;
    pidc_pkg::entry_t push_entry;
    pidc_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             not_full;
    logic             not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pidc_pkg::REG_GAIN_P:
                    cfg_next.gain_p = $signed(cfg_data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_GAIN_I:
                    cfg_next.gain_i = $signed(cfg_data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_GAIN_D:
                    cfg_next.gain_d = $signed(cfg_data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_INTEGRAL_LIMIT:
                    cfg_next.integral_limit = cfg_data[pidc_pkg::ILIM_W-1:0];
                pidc_pkg::REG_OUTPUT_LIMIT:
                    cfg_next.output_limit = cfg_data[pidc_pkg::OLIM_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= '0;
            cfg_reg.output_limit   <= pidc_pkg::OUTPUT_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pidc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .queue_ready (not_full),
        .push        (push),
        .entry       (push_entry)
    );

    pidc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (not_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    pidc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .queue_not_empty (not_empty),
        .head            (head),
        .pop             (pop),
        .rsp             (rsp)
    );

endmodule

FILE: tb/pidc_drive_check.sv
// Drive predictor and scoreboard for the clamped PID controller.
// Watches the sample, drive and register channels; depends on pidc_pkg and pidc_if.
module pidc_drive_check
(
    input  logic                             clk,
    input  logic                             rst_n,
    pidc_req_if                              req,
    pidc_rsp_if                              rsp,
    input  logic                             cfg_we,
    input  logic [pidc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               pending,
    output int                               fails
);

    logic signed [pidc_pkg::GAIN_W-1:0]   kp;
    logic signed [pidc_pkg::GAIN_W-1:0]   ki;
    logic signed [pidc_pkg::GAIN_W-1:0]   kd;
    logic [pidc_pkg::ILIM_W-1:0]          ilim;
    logic [pidc_pkg::OLIM_W-1:0]          olim;
    longint                               integ;
    longint                               last_err;
    bit                                   last_valid;
    logic signed [pidc_pkg::SAMPLE_W-1:0] drive_q [$];

    always @(posedge clk or negedge rst_n)
    begin : predict
        longint                               err;
        longint                               deriv;
        longint                               sum;
        logic signed [pidc_pkg::SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            ilim       = '0;
            olim       = pidc_pkg::OUTPUT_LIMIT_RESET;
            integ      = 0;
            last_err   = 0;
            last_valid = 0;
            drive_q.delete();
            pending <= 0;
            fails   <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("drive: expected none, actual %0d", rsp.drive);
                    fails <= fails + 1;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (rsp.drive !== want)
                    begin
                        $error("drive: expected %0d, actual %0d", want, rsp.drive);
                        fails <= fails + 1;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                err   = longint'($signed(req.target)) - longint'($signed(req.measured));
                integ = integ + ((longint'($signed(ki)) * err) >>> 8);
                if (integ > longint'(ilim))
                    integ = longint'(ilim);
                else if (integ < -longint'(ilim))
                    integ = -longint'(ilim);
                deriv = 0;
                if (last_valid)
                    deriv = (longint'($signed(kd)) * (err - last_err)) >>> 8;
                sum = ((longint'($signed(kp)) * err) >>> 8) + integ + deriv;
                if (sum > longint'(olim))
                    sum = longint'(olim);
                else if (sum < -longint'(olim))
                    sum = -longint'(olim);
                drive_q.push_back(sum[pidc_pkg::SAMPLE_W-1:0]);
                last_err   = err;
                last_valid = 1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pidc_pkg::REG_GAIN_P:         kp   = cfg_data[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_GAIN_I:         ki   = cfg_data[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_GAIN_D:         kd   = cfg_data[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_INTEGRAL_LIMIT: ilim = cfg_data[pidc_pkg::ILIM_W-1:0];
                    pidc_pkg::REG_OUTPUT_LIMIT:   olim = cfg_data[pidc_pkg::OLIM_W-1:0];
                    default:                      ;
                endcase
            end
            pending <= drive_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the clamped PID controller testbench: clock, reset, sample and register stimulus.
// Depends on pidc_pkg, pidc_if, pid_controller_clamped and pidc_drive_check.
module tb_top;

    localparam int LIMIT   = 400000;
    localparam int SETTLE  = 6;
    localparam int MAX_GAP = 19;
    localparam int PHASES  = 11;
    localparam int PER_PHASE = 100;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [pidc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                               pending;
    int                               fails;
    int                               cycles = 0;
    bit                               steady = 0;
    logic signed [pidc_pkg::SAMPLE_W-1:0] corner [4] = '{-32768, 32767, 0, -1};

    pidc_req_if req ();
    pidc_rsp_if rsp ();

    pid_controller_clamped dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pidc_drive_check drive_chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .fails     (fails)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic signed [pidc_pkg::GAIN_W-1:0] draw_gain();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return pidc_pkg::GAIN_W'($urandom);
            3, 4:    return pidc_pkg::GAIN_W'($urandom_range(0, 1024) - 512);
            default: return '0;
        endcase
    endfunction

    task automatic put_reg(input logic [pidc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pidc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write every register with junk in the unused upper bits, then poke unmapped indexes.
    task automatic apply_settings(input logic signed [pidc_pkg::GAIN_W-1:0] kp, ki, kd,
                                  input logic [pidc_pkg::ILIM_W-1:0] il,
                                  input logic [pidc_pkg::OLIM_W-1:0] ol);
        logic [pidc_pkg::CFG_DATA_W-1:0] d;
        wait_idle();
        d = pidc_pkg::CFG_DATA_W'($urandom);
        d[pidc_pkg::GAIN_W-1:0] = kp;
        put_reg(pidc_pkg::REG_GAIN_P, d);
        d = pidc_pkg::CFG_DATA_W'($urandom);
        d[pidc_pkg::GAIN_W-1:0] = ki;
        put_reg(pidc_pkg::REG_GAIN_I, d);
        d = pidc_pkg::CFG_DATA_W'($urandom);
        d[pidc_pkg::GAIN_W-1:0] = kd;
        put_reg(pidc_pkg::REG_GAIN_D, d);
        put_reg(pidc_pkg::REG_INTEGRAL_LIMIT, il);
        d = pidc_pkg::CFG_DATA_W'($urandom);
        d[pidc_pkg::OLIM_W-1:0] = ol;
        put_reg(pidc_pkg::REG_OUTPUT_LIMIT, d);
        for (int i = pidc_pkg::REG_OUTPUT_LIMIT + 1; i < (1 << pidc_pkg::CFG_INDEX_W); i++)
            put_reg(i[pidc_pkg::CFG_INDEX_W-1:0], pidc_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [pidc_pkg::SAMPLE_W-1:0] t, m);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.target   <= t;
        req.measured <= m;
        do @(posedge clk); while (!req.ready);
    endtask

    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    initial
    begin
        logic signed [pidc_pkg::SAMPLE_W-1:0] t;
        logic signed [pidc_pkg::SAMPLE_W-1:0] m;
        logic [pidc_pkg::ILIM_W-1:0]          il;
        logic [pidc_pkg::OLIM_W-1:0]          ol;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req.valid    = 1'b0;
        req.target   = '0;
        req.measured = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // first step after reset has no derivative term; integral saturates on the big error
        apply_settings(16'sh0100, 16'sh0100, 16'sh0200, 20000, 32767);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(0, 0);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(100, -50);
        send_sample(-1, 0);
        send_sample(0, 1);
        send_sample(1000, 0);
        send_sample(1000, 0);
        send_sample(1000, 0);
        req.valid <= 1'b0;

        // lowered integral limit clamps the stored sum on the next step
        apply_settings(16'sh0100, 16'sh0040, 16'sh0100, 100, 1000);
        send_sample(5, 0);
        send_sample(-5, 0);
        send_sample(32767, -32768);
        req.valid <= 1'b0;

        // zero limits with extreme gains
        apply_settings(16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(123, -456);
        req.valid <= 1'b0;

        apply_settings(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8388607, 32767);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(0, 0);
        send_sample(-12345, 999);
        req.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:       il = '0;
                1:       il = 8388607;
                2:       il = pidc_pkg::ILIM_W'($urandom);
                default: il = pidc_pkg::ILIM_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       ol = '0;
                1:       ol = 32767;
                2:       ol = pidc_pkg::OLIM_W'($urandom);
                default: ol = pidc_pkg::OLIM_W'($urandom_range(0, 2000));
            endcase
            apply_settings(draw_gain(), draw_gain(), draw_gain(), il, ol);
            steady = (p % 4 == 1);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                t = pidc_pkg::SAMPLE_W'($urandom);
                case ($urandom_range(0, 3))
                    0:       m = pidc_pkg::SAMPLE_W'($urandom);
                    3:
                    begin
                        t = corner[$urandom_range(0, 3)];
                        m = corner[$urandom_range(0, 3)];
                    end
                    default: m = pidc_pkg::SAMPLE_W'(t + $urandom_range(0, 400) - 200);
                endcase
                send_sample(t, m);
            end
            req.valid <= 1'b0;
        end
        steady = 0;

        wait_idle();
        if (fails == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
